// ===== sv/bgd_pkg.sv =====
// Shared types and constants for the button gesture detector.
// Used by bgd_ctrl, bgd_dp and button_gesture_detector; depends on nothing.
`default_nettype none

package bgd_pkg;

    localparam int BUTTON_COUNT = 8;
    localparam int GROUP_COUNT  = 4;

    localparam int BTN_W   = 3;
    localparam int GRP_W   = 2;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 9;
    localparam int TAP_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 3;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_ENABLE_MASK     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ACTIVE_LOW_MASK = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_GROUP_MAP       = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_POLL_INTERVAL   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_CLICK_MAX       = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_LONG_PRESS_MIN  = 3'd5;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_CLICKED  = 2'd2,
        EV_LONG     = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [BTN_W-1:0]  idx;
        ev_kind_t          kind;
        logic [TIME_W-1:0] elapsed;
        logic [CNT_W-1:0]  count;
    } bgd_event_t;

    // Controller to datapath
    typedef struct packed {
        logic             start;
        logic             push;
        logic             push_sel;
        logic             commit;
        logic             flush;
        logic [BTN_W-1:0] btn;
    } bgd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] ev_cnt;
        logic       p_vld;
        logic       out_free;
    } bgd_status_t;

endpackage

`default_nettype wire

// ===== sv/bgd_dp.sv =====
// Datapath: configuration registers, millisecond clock, per-button and group
// state, event evaluation, pending beat and output register. Uses bgd_pkg.
`default_nettype none

module bgd_dp
    import bgd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_A_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic [BUTTON_COUNT-1:0] raw_levels,
    input  wire bgd_cmd_t                cmd,
    output bgd_status_t                  st,
    input  wire logic                    out_stall,
    output logic                         out_valid,
    output bgd_event_t                   out_ev,
    output logic                         out_last
);

    logic [BUTTON_COUNT-1:0]          enable_reg;
    logic [BUTTON_COUNT-1:0]          active_low_reg;
    logic [BUTTON_COUNT-1:0][GRP_W-1:0] group_map_reg;
    logic [9:0]                       poll_reg;
    logic [15:0]                      click_max_reg;
    logic [15:0]                      long_min_reg;

    logic [TIME_W-1:0] clock_reg;
    logic [BUTTON_COUNT-1:0] raw_reg;

    logic              pressed_reg [BUTTON_COUNT];
    logic [TIME_W-1:0] changed_reg [BUTTON_COUNT];
    logic [TAP_W-1:0]  tap_reg     [BUTTON_COUNT];
    logic              long_reg    [BUTTON_COUNT];
    logic [TIME_W-1:0] tapdur_reg  [BUTTON_COUNT];
    logic              gvalid_reg  [GROUP_COUNT];
    logic [BTN_W-1:0]  glast_reg   [GROUP_COUNT];

    logic              p_vld_reg;
    bgd_event_t        p_ev_reg;
    logic              o_vld_reg;
    bgd_event_t        o_ev_reg;
    logic              o_last_reg;

    logic [BUTTON_COUNT-1:0] en_rise;
    logic [BTN_W-1:0]  b;
    logic              en;
    logic              pr;
    logic [TIME_W-1:0] delta;
    logic [GRP_W-1:0]  g_raw;
    logic [GRP_W-1:0]  g;
    logic              is_last;
    logic              out_free;
    logic              o_load;

    logic              pressed_next;
    logic              chg_upd;
    logic [TAP_W-1:0]  tap_next;
    logic [TIME_W-1:0] tapdur_next;
    logic              long_next;
    logic              grp_upd;
    logic [1:0]        ev_cnt;
    bgd_event_t        ev0;
    bgd_event_t        ev1;
    bgd_event_t        ev_sel;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '0;
            active_low_reg <= '0;
            group_map_reg  <= '0;
            poll_reg       <= 10'd10;
            click_max_reg  <= 16'd300;
            long_min_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE_MASK:     enable_reg     <= cfg_data[BUTTON_COUNT-1:0];
                REG_ACTIVE_LOW_MASK: active_low_reg <= cfg_data[BUTTON_COUNT-1:0];
                REG_GROUP_MAP:       group_map_reg  <= cfg_data;
                REG_POLL_INTERVAL:   poll_reg       <= cfg_data[9:0];
                REG_CLICK_MAX:       click_max_reg  <= cfg_data;
                REG_LONG_PRESS_MIN:  long_min_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Buttons that get enabled by this write start over from reset values
    assign en_rise = (cfg_we && cfg_index == REG_ENABLE_MASK)
                   ? (cfg_data[BUTTON_COUNT-1:0] & ~enable_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
        end
        else if (cmd.start)
        begin
            clock_reg <= clock_reg + TIME_W'(poll_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            raw_reg <= raw_levels;
        end
    end

    // Evaluate the button being visited
    assign b     = cmd.btn;
    assign en    = enable_reg[b];
    assign pr    = raw_reg[b] ^ active_low_reg[b];
    assign delta = clock_reg - changed_reg[b];
    assign g_raw = group_map_reg[b];
    assign g     = ({1'b0, g_raw} >= (GRP_W+1)'(GROUP_COUNT))
                 ? GRP_W'(GROUP_COUNT - 1) : g_raw;
    assign is_last = gvalid_reg[g] && (glast_reg[g] == b);

    always_comb
    begin
        pressed_next = pressed_reg[b];
        chg_upd      = 1'b0;
        tap_next     = tap_reg[b];
        tapdur_next  = tapdur_reg[b];
        long_next    = long_reg[b];
        grp_upd      = 1'b0;
        ev_cnt       = 2'd0;
        ev0 = '{idx: b, kind: EV_PRESSED, elapsed: delta, count: CNT_W'(1)};
        ev1 = '{idx: b, kind: EV_CLICKED, elapsed: delta, count: CNT_W'(1)};
        if (en)
        begin
            if (pressed_reg[b] != pr)
            begin
                pressed_next = pr;
                chg_upd      = 1'b1;
                ev_cnt       = 2'd1;
                if (!pr)
                begin
                    ev0.kind = EV_RELEASED;
                    if (delta < TIME_W'(click_max_reg))
                    begin
                        if (tap_reg[b] != '1)
                        begin
                            tap_next = tap_reg[b] + TAP_W'(1);
                        end
                        tapdur_next = delta;
                    end
                    else if (long_reg[b] && is_last)
                    begin
                        // slow release: immediate click
                        ev_cnt   = 2'd2;
                        tap_next = '0;
                    end
                end
                else
                begin
                    ev0.kind  = EV_PRESSED;
                    grp_upd   = 1'b1;
                    long_next = 1'b1;
                end
            end
            else if (pr)
            begin
                if (delta > TIME_W'(long_min_reg) && long_reg[b])
                begin
                    ev_cnt      = 2'd1;
                    ev0.kind    = EV_LONG;
                    ev0.elapsed = '0;
                    ev0.count   = CNT_W'(tap_reg[b]) + CNT_W'(1);
                    long_next   = 1'b0;
                end
            end
            else if (delta > TIME_W'(click_max_reg) && tap_reg[b] != '0)
            begin
                // quiet gap over: report the multi-click
                if (long_reg[b] && is_last)
                begin
                    ev_cnt      = 2'd1;
                    ev0.kind    = EV_CLICKED;
                    ev0.elapsed = (tap_reg[b] == TAP_W'(1)) ? tapdur_reg[b] : '0;
                    ev0.count   = CNT_W'(tap_reg[b]);
                end
                tap_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                pressed_reg[i] <= 1'b0;
                changed_reg[i] <= '0;
                tap_reg[i]     <= '0;
                long_reg[i]    <= 1'b1;
                tapdur_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (en_rise[i])
                begin
                    pressed_reg[i] <= 1'b0;
                    changed_reg[i] <= '0;
                    tap_reg[i]     <= '0;
                    long_reg[i]    <= 1'b1;
                    tapdur_reg[i]  <= '0;
                end
                else if (cmd.commit && b == BTN_W'(i))
                begin
                    pressed_reg[i] <= pressed_next;
                    if (chg_upd)
                    begin
                        changed_reg[i] <= clock_reg;
                    end
                    tap_reg[i]    <= tap_next;
                    long_reg[i]   <= long_next;
                    tapdur_reg[i] <= tapdur_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < GROUP_COUNT; j++)
            begin
                gvalid_reg[j] <= 1'b0;
                glast_reg[j]  <= '0;
            end
        end
        else if (cmd.commit && grp_upd)
        begin
            gvalid_reg[g] <= 1'b1;
            glast_reg[g]  <= b;
        end
    end

    // Pending beat and output register: the pending beat moves out once the
    // next event shows up, or at the end of the tick marked as last.
    assign ev_sel   = cmd.push_sel ? ev1 : ev0;
    assign out_free = !o_vld_reg || !out_stall;
    assign o_load   = (cmd.push && p_vld_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                p_vld_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                p_vld_reg <= 1'b0;
            end
            if (o_load)
            begin
                o_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            p_ev_reg <= ev_sel;
        end
        if (o_load)
        begin
            o_ev_reg   <= p_ev_reg;
            o_last_reg <= cmd.flush;
        end
    end

    assign st.ev_cnt   = ev_cnt;
    assign st.p_vld    = p_vld_reg;
    assign st.out_free = out_free;

    assign out_valid = o_vld_reg;
    assign out_ev    = o_ev_reg;
    assign out_last  = o_last_reg;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && p_vld_reg) |-> out_free)
        else $error("pending beat pushed while output register is blocked");

    a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (p_vld_reg && out_free && !cmd.push))
        else $error("flush without a pending beat or without room");
`endif

endmodule

`default_nettype wire

// ===== sv/bgd_ctrl.sv =====
// Controller: accepts a tick, sweeps the buttons in index order and issues
// push, commit and flush commands to bgd_dp. Uses bgd_pkg.
`default_nettype none

module bgd_ctrl
    import bgd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire bgd_status_t st,
    output bgd_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [BTN_W-1:0] btn_reg;
    logic [BTN_W-1:0] btn_next;
    logic             sub_reg;
    logic             sub_next;
    logic             can_push;
    logic             last_btn;

    assign in_stall = (state_reg != S_IDLE);
    assign can_push = !st.p_vld || st.out_free;
    assign last_btn = (btn_reg == BTN_W'(BUTTON_COUNT - 1));

    always_comb
    begin
        state_next   = state_reg;
        btn_next     = btn_reg;
        sub_next     = sub_reg;
        cmd.start    = 1'b0;
        cmd.push     = 1'b0;
        cmd.push_sel = sub_reg;
        cmd.commit   = 1'b0;
        cmd.flush    = 1'b0;
        cmd.btn      = btn_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    btn_next   = '0;
                    sub_next   = 1'b0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.ev_cnt == 2'd0)
                begin
                    cmd.commit = 1'b1;
                end
                else if (can_push)
                begin
                    cmd.push = 1'b1;
                    // commit once the last event of this button is out
                    if ({1'b0, sub_reg} == st.ev_cnt - 2'd1)
                    begin
                        cmd.commit = 1'b1;
                        sub_next   = 1'b0;
                    end
                    else
                    begin
                        sub_next = 1'b1;
                    end
                end
                if (cmd.commit)
                begin
                    if (last_btn)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        btn_next = btn_reg + BTN_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (!st.p_vld)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            btn_reg   <= '0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            btn_reg   <= btn_next;
            sub_reg   <= sub_next;
        end
    end

`ifndef ASSERT_OFF
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !st.p_vld)
        else $error("pending beat left over after tick");
`endif

endmodule

`default_nettype wire

// ===== sv/button_gesture_detector.sv =====
// Button gesture detector top level: bgd_ctrl sequencer plus bgd_dp datapath.
// Depends on bgd_pkg, bgd_ctrl and bgd_dp.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   in        in_valid / in_stall    raw_levels
//   out       out_valid / out_stall  button_index, event_kind, elapsed_ms,
//                                    click_total, last_of_tick
//   cfg       cfg_we                 cfg_index, cfg_data
//
// A tick takes an accept step, one visit per button in index order (8), one more
// step for each button that emits two events, and one closing step. Two events
// need the button to be the last pressed in its group, so at most one button
// per group (4) adds a step to the controller's sweep.
// Reset clears all state at once, but for the sampled levels and the event payload registers; no clearing pass.
// Output stall holds the sweep only when the pending beat cannot move out.
`default_nettype none

module button_gesture_detector
    import bgd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_A_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [BUTTON_COUNT-1:0] raw_levels,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [BTN_W-1:0]             button_index,
    output logic [1:0]                   event_kind,
    output logic [TIME_W-1:0]            elapsed_ms,
    output logic [CNT_W-1:0]             click_total,
    output logic                         last_of_tick
);

    bgd_cmd_t    cmd;
    bgd_status_t st;
    bgd_event_t  out_ev;

    bgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bgd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .raw_levels (raw_levels),
        .cmd        (cmd),
        .st         (st),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_ev     (out_ev),
        .out_last   (last_of_tick)
    );

    assign button_index = out_ev.idx;
    assign event_kind   = out_ev.kind;
    assign elapsed_ms   = out_ev.elapsed;
    assign click_total  = out_ev.count;

endmodule

`default_nettype wire
